/* sv/bmap_pkg.sv */
// Shared types, constants and helper functions for the button-to-scale note mapper.
package bmap_pkg;

    localparam int SLOT_COUNT   = 4;
    localparam int JOB_DEPTH    = 2;
    localparam int RESULT_DEPTH = 2;

    localparam logic [2:0] SCALE_MINPENT   = 3'd0;
    localparam logic [2:0] SCALE_MAJOR     = 3'd1;
    localparam logic [2:0] SCALE_MINOR     = 3'd2;
    localparam logic [2:0] SCALE_DORIAN    = 3'd3;
    localparam logic [2:0] SCALE_PHRYGIAN  = 3'd4;
    localparam logic [2:0] SCALE_CHROMATIC = 3'd5;
    localparam logic [2:0] SCALE_LAST      = SCALE_CHROMATIC;

    localparam logic signed [3:0] OCT_MIN = -4'sd4;
    localparam logic signed [3:0] OCT_MAX = 4'sd4;

    localparam logic [6:0] ROOT_RESET = 7'd60;
    localparam logic [6:0] NOTE_MAX   = 7'd127;
    localparam logic [6:0] VELOCITY_ON = 7'd100;

    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_STATUS   = 2'd2;

    typedef struct packed {
        logic       scale_prev_level;
        logic       scale_next_level;
        logic       octave_up_level;
        logic       octave_down_level;
        logic       root_down_level;
        logic       root_up_level;
        logic       panic_level;
        logic [3:0] press_mask;
        logic [3:0] release_mask;
    } in_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [6:0]        note_num;
        logic [1:0]        degree;
        logic signed [3:0] note_octave;
        logic [6:0]        velocity;
        logic              all_notes_off;
        logic [6:0]        root_note;
        logic signed [3:0] octave_shift;
        logic [2:0]        scale_mode;
        logic              last;
    } out_t;

    // One classified frame: the note events it causes and the settings after it.
    typedef struct packed {
        logic [3:0]        on_mask;
        logic [3:0][6:0]   on_note;
        logic signed [3:0] on_oct;
        logic [3:0]        off_mask;
        logic [3:0][6:0]   off_note;
        logic [3:0][3:0]   off_oct;
        logic              panic;
        logic [6:0]        root;
        logic signed [3:0] octave;
        logic [2:0]        scale;
    } job_t;

    // Scale interval of degree slot within a scale mode.
    function automatic logic [3:0] interval(input logic [2:0] scale, input logic [1:0] slot);
        logic [3:0][3:0] row;
        begin
            unique case (scale)
                SCALE_MAJOR:     row = {4'd5, 4'd4, 4'd2, 4'd0};
                SCALE_MINOR:     row = {4'd5, 4'd3, 4'd2, 4'd0};
                SCALE_DORIAN:    row = {4'd5, 4'd3, 4'd2, 4'd0};
                SCALE_PHRYGIAN:  row = {4'd5, 4'd3, 4'd1, 4'd0};
                SCALE_CHROMATIC: row = {4'd3, 4'd2, 4'd1, 4'd0};
                default:         row = {4'd7, 4'd5, 4'd3, 4'd0};
            endcase
            interval = row[slot];
        end
    endfunction

    // Index of the lowest set bit of a nonzero 4-bit mask.
    function automatic logic [1:0] lowest_slot(input logic [3:0] mask);
        begin
            if (mask[0])
            begin
                lowest_slot = 2'd0;
            end
            else if (mask[1])
            begin
                lowest_slot = 2'd1;
            end
            else if (mask[2])
            begin
                lowest_slot = 2'd2;
            end
            else
            begin
                lowest_slot = 2'd3;
            end
        end
    endfunction

endpackage

/* sv/button_to_scale_note_mapper.sv */
// Top level of the button-to-scale note mapper: front end, job queue, back end, result queue.
//
// Usage:
//   Input channel: one controller frame per request (seven mode-button levels and
//   the note-slot press and release masks). Push a request when full is low.
//   Result channel: a queue of note events; while empty is low the oldest result
//   sits on the result port, raise pop to take it.
//   Each frame yields its note-on results (slot 0..3), then its note-off results
//   (slot 0..3), then one status result with last set.
// Timing:
//   A frame's first result passes through the job queue and then the result queue
//   before it is visible. The back end issues one result per cycle while the result
//   queue has room; a frame yields 1 to 9 results: one per note-on, one per note-off,
//   one for the status. A new frame is taken while the back end still works on earlier
//   ones, as long as the job queue (JobDepth entries) has room.
// Reset: root note 60, octave shift 0, minor pentatonic, no held notes, both
//   queues empty.
// Stall: when pop stays low the result queue fills, the back end holds its job,
//   the job queue fills and full rises; no result is lost or repeated.
module button_to_scale_note_mapper
    import bmap_pkg::*;
#(
    parameter int JobDepth    = JOB_DEPTH,
    parameter int ResultDepth = RESULT_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  in_t  frame,
    output logic empty,
    input  logic pop,
    output out_t result
);

    job_t job_in;
    job_t job_out;
    logic job_empty;
    logic job_pop;
    logic accept;
    out_t item;
    logic item_push;
    logic item_full;
    logic [$bits(job_t)-1:0] job_rdata;
    logic [$bits(out_t)-1:0] result_rdata;

    // Take a frame only when the job queue has room.
    assign accept = push && !full;

    bmap_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .frame  (frame),
        .job    (job_in)
    );

    // Decouple classification from result issue.
    bmap_fifo #(
        .Width ($bits(job_t)),
        .Depth (JobDepth)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (job_in),
        .full  (full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    assign job_out = job_t'(job_rdata);

    bmap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .item      (item),
        .item_push (item_push),
        .item_full (item_full)
    );

    // Hold finished results until the receiver pops them.
    bmap_fifo #(
        .Width ($bits(out_t)),
        .Depth (ResultDepth)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata (item),
        .full  (item_full),
        .pop   (pop),
        .rdata (result_rdata),
        .empty (empty)
    );

    assign result = out_t'(result_rdata);

endmodule

/* sv/bmap_fifo.sv */
// Small register queue with push/full and pop/empty sides.
module bmap_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [Width-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [Width-1:0] rdata,
    output logic             empty
);

    localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    logic [Depth-1:0][Width-1:0] mem_reg;
    logic [AddrW-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0]           count_reg, count_next;
    logic                        push_ok;
    logic                        pop_ok;

    assign full    = (count_reg == CountW'(Depth));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AddrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AddrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/bmap_front.sv */
// Front end: detect button edges, update mode state and held notes, build a job.
module bmap_front
    import bmap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  in_t  frame,
    output job_t job
);

    logic [6:0]        root_reg, root_next;
    logic signed [3:0] octave_reg, octave_next;
    logic [2:0]        scale_reg, scale_next;
    logic [6:0]        history_reg;
    logic [3:0]        valid_reg, valid_next;
    logic [3:0][6:0]   note_reg, note_next;
    logic [3:0][3:0]   oct_reg, oct_next;

    logic [6:0]        levels;
    logic [6:0]        edges;
    logic [2:0]        scale_mid;
    logic signed [3:0] octave_mid;
    logic [6:0]        root_mid;
    logic signed [9:0] oct_x;
    logic signed [9:0] oct12;
    logic signed [9:0] sum;
    logic [3:0]        valid_mid;
    logic [3:0][6:0]   new_note;

    assign levels = {frame.panic_level, frame.root_up_level, frame.root_down_level,
                     frame.octave_down_level, frame.octave_up_level,
                     frame.scale_next_level, frame.scale_prev_level};
    assign edges  = levels & ~history_reg;

    always_comb
    begin
        // Apply mode edges in fixed order: scale steps wrap, octave and root steps clamp.
        scale_mid  = (edges[0]) ? ((scale_reg == '0) ? SCALE_LAST : scale_reg - 1'b1)
                                : scale_reg;
        scale_next = (edges[1]) ? ((scale_mid >= SCALE_LAST) ? '0 : scale_mid + 1'b1)
                                : scale_mid;
        octave_mid  = (edges[2] && octave_reg != OCT_MAX) ? octave_reg + 4'sd1 : octave_reg;
        octave_next = (edges[3] && octave_mid != OCT_MIN) ? octave_mid - 4'sd1 : octave_mid;
        root_mid  = (edges[4] && root_reg != '0) ? root_reg - 1'b1 : root_reg;
        root_next = (edges[5] && root_mid != NOTE_MAX) ? root_mid + 1'b1 : root_mid;
        valid_mid = edges[6] ? '0 : valid_reg;

        oct_x = {{6{octave_next[3]}}, octave_next};
        oct12 = (oct_x <<< 3) + (oct_x <<< 2);

        valid_next = valid_reg;
        note_next  = note_reg;
        oct_next   = oct_reg;
        sum        = '0;
        new_note   = '0;
        job        = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            sum = $signed({3'b000, root_next})
                + $signed({6'b000000, interval(scale_next, 2'(i))}) + oct12;
            if (sum < 0)
            begin
                new_note[i] = '0;
            end
            else if (sum > $signed({3'b000, NOTE_MAX}))
            begin
                new_note[i] = NOTE_MAX;
            end
            else
            begin
                new_note[i] = sum[6:0];
            end
            // A press in the same frame as a release turns the new note off at once.
            job.on_mask[i]  = frame.press_mask[i];
            job.on_note[i]  = new_note[i];
            job.off_mask[i] = frame.release_mask[i] && (frame.press_mask[i] || valid_mid[i]);
            job.off_note[i] = frame.press_mask[i] ? new_note[i] : note_reg[i];
            job.off_oct[i]  = frame.press_mask[i] ? octave_next : oct_reg[i];
            valid_next[i]   = (frame.press_mask[i] || valid_mid[i]) && !frame.release_mask[i];
            if (frame.press_mask[i])
            begin
                note_next[i] = new_note[i];
                oct_next[i]  = octave_next;
            end
        end
        job.on_oct = octave_next;
        job.panic  = edges[6];
        job.root   = root_next;
        job.octave = octave_next;
        job.scale  = scale_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg    <= ROOT_RESET;
            octave_reg  <= '0;
            scale_reg   <= SCALE_MINPENT;
            history_reg <= '0;
            valid_reg   <= '0;
        end
        else if (accept)
        begin
            root_reg    <= root_next;
            octave_reg  <= octave_next;
            scale_reg   <= scale_next;
            history_reg <= levels;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            note_reg <= note_next;
            oct_reg  <= oct_next;
        end
    end

endmodule

/* sv/bmap_back.sv */
// Back end: walk one job and issue its note-on, note-off and status results.
module bmap_back
    import bmap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  job_t job,
    input  logic job_empty,
    output logic job_pop,
    output out_t item,
    output logic item_push,
    input  logic item_full
);

    logic       active_reg, active_next;
    logic [3:0] on_left_reg, on_left_next;
    logic [3:0] off_left_reg, off_left_next;
    logic [3:0] cur_on;
    logic [3:0] cur_off;
    logic [1:0] slot;
    logic       go;

    assign cur_on  = active_reg ? on_left_reg : job.on_mask;
    assign cur_off = active_reg ? off_left_reg : job.off_mask;
    assign go      = !job_empty && !item_full;

    always_comb
    begin
        item               = '0;
        item.root_note     = job.root;
        item.octave_shift  = job.octave;
        item.scale_mode    = job.scale;
        slot               = '0;
        job_pop            = 1'b0;
        active_next        = active_reg;
        on_left_next       = on_left_reg;
        off_left_next      = off_left_reg;
        if (cur_on != '0)
        begin
            // Issue note-ons lowest slot first.
            slot             = lowest_slot(cur_on);
            item.event_kind  = KIND_NOTE_ON;
            item.note_num    = job.on_note[slot];
            item.degree      = slot;
            item.note_octave = job.on_oct;
            item.velocity    = VELOCITY_ON;
        end
        else if (cur_off != '0)
        begin
            slot             = lowest_slot(cur_off);
            item.event_kind  = KIND_NOTE_OFF;
            item.note_num    = job.off_note[slot];
            item.degree      = slot;
            item.note_octave = job.off_oct[slot];
            item.velocity    = VELOCITY_ON;
        end
        else
        begin
            item.event_kind    = KIND_STATUS;
            item.all_notes_off = job.panic;
            item.last          = 1'b1;
        end
        if (go)
        begin
            if (item.last)
            begin
                job_pop     = 1'b1;
                active_next = 1'b0;
            end
            else
            begin
                // Drop the slot just issued from the remaining masks.
                active_next   = 1'b1;
                on_left_next  = cur_on & (cur_on - 1'b1);
                off_left_next = (cur_on != '0) ? cur_off : cur_off & (cur_off - 1'b1);
            end
        end
    end

    assign item_push = go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            on_left_reg  <= '0;
            off_left_reg <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            on_left_reg  <= on_left_next;
            off_left_reg <= off_left_next;
        end
    end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the button-to-scale note mapper: frame predictor, drivers and checks.
module tb
    import bmap_pkg::*;
();

    class note_event_board;
        int         root;
        int         octave;
        logic [2:0] scale;
        in_t        last_levels;
        bit         held_valid [SLOT_COUNT];
        int         held_note [SLOT_COUNT];
        int         held_oct [SLOT_COUNT];
        out_t       pending_events [$];
        int         mismatches;

        function new();
            root        = int'(ROOT_RESET);
            octave      = 0;
            scale       = SCALE_MINPENT;
            last_levels = '0;
            mismatches  = 0;
            foreach (held_valid[i])
            begin
                held_valid[i] = 1'b0;
                held_note[i]  = 0;
                held_oct[i]   = 0;
            end
        endfunction

        static function int clip(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function out_t event_item(logic [1:0] kind, int note, int slot, int oct,
                                  bit panic, bit fin);
            out_t e;
            e.event_kind    = kind;
            e.note_num      = 7'(note);
            e.degree        = 2'(slot);
            e.note_octave   = 4'(oct);
            e.velocity      = (kind == KIND_STATUS) ? 7'd0 : VELOCITY_ON;
            e.all_notes_off = panic;
            e.root_note     = 7'(root);
            e.octave_shift  = 4'(octave);
            e.scale_mode    = scale;
            e.last          = fin;
            return e;
        endfunction

        // Queue one expected result behind the ones already waiting.
        function void expect_event(out_t e);
            pending_events.insert(pending_events.size(), e);
        endfunction

        // Advance the settings and held notes by one frame and queue its events.
        function void predict_events(in_t f);
            in_t rise;
            int  row [SLOT_COUNT];
            bit  on_f [SLOT_COUNT];
            bit  off_f [SLOT_COUNT];
            int  on_note [SLOT_COUNT];
            int  off_note [SLOT_COUNT];
            int  off_oct [SLOT_COUNT];
            int  note;
            rise = f & ~last_levels;
            last_levels = f;
            last_levels.press_mask = '0;
            last_levels.release_mask = '0;
            if (scale > SCALE_LAST)
                scale = SCALE_MINPENT;
            if (rise.scale_prev_level)
                scale = (scale == SCALE_MINPENT) ? SCALE_LAST : scale - 3'd1;
            if (rise.scale_next_level)
                scale = (scale == SCALE_LAST) ? SCALE_MINPENT : scale + 3'd1;
            if (rise.octave_up_level)
                octave = clip(octave + 1, OCT_MIN, OCT_MAX);
            if (rise.octave_down_level)
                octave = clip(octave - 1, OCT_MIN, OCT_MAX);
            if (rise.root_down_level)
                root = clip(root - 1, 0, NOTE_MAX);
            if (rise.root_up_level)
                root = clip(root + 1, 0, NOTE_MAX);
            if (rise.panic_level)
            begin
                foreach (held_valid[i])
                    held_valid[i] = 1'b0;
            end
            case (scale) inside
                SCALE_MAJOR:                row = '{0, 2, 4, 5};
                SCALE_MINOR, SCALE_DORIAN:  row = '{0, 2, 3, 5};
                SCALE_PHRYGIAN:             row = '{0, 1, 3, 5};
                SCALE_CHROMATIC:            row = '{0, 1, 2, 3};
                default:                    row = '{0, 3, 5, 7};
            endcase
            // a slot is pressed before it is released, so both in one frame leave it empty
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                on_f[i]  = 1'b0;
                off_f[i] = 1'b0;
                if (f.press_mask[i])
                begin
                    note          = clip(root + row[i] + 12 * octave, 0, NOTE_MAX);
                    held_valid[i] = 1'b1;
                    held_note[i]  = note;
                    held_oct[i]   = octave;
                    on_f[i]       = 1'b1;
                    on_note[i]    = note;
                end
                if (f.release_mask[i] && held_valid[i])
                begin
                    off_f[i]      = 1'b1;
                    off_note[i]   = held_note[i];
                    off_oct[i]    = held_oct[i];
                    held_valid[i] = 1'b0;
                end
            end
            for (int i = 0; i < SLOT_COUNT; i++)
                if (on_f[i])
                    expect_event(event_item(KIND_NOTE_ON, on_note[i], i, octave, 0, 0));
            for (int i = 0; i < SLOT_COUNT; i++)
                if (off_f[i])
                    expect_event(
                        event_item(KIND_NOTE_OFF, off_note[i], i, off_oct[i], 0, 0));
            expect_event(event_item(KIND_STATUS, 0, 0, 0, rise.panic_level, 1));
        endfunction

        function string describe(out_t e);
            return $sformatf({"kind=%0d note=%0d deg=%0d oct=%0d vel=%0d off=%0b",
                              " root=%0d shift=%0d scale=%0d last=%0b"},
                             e.event_kind, e.note_num, e.degree, e.note_octave, e.velocity,
                             e.all_notes_off, e.root_note, e.octave_shift, e.scale_mode,
                             e.last);
        endfunction

        function void check_event(out_t got);
            out_t  want;
            string bad;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result\n  expected none\n  actual   %s",
                             describe(got));
                return;
            end
            want = pending_events.pop_front();
            bad = "";
            if (got.event_kind !== want.event_kind)       bad = {bad, " event_kind"};
            if (got.note_num !== want.note_num)           bad = {bad, " note_num"};
            if (got.degree !== want.degree)               bad = {bad, " degree"};
            if (got.note_octave !== want.note_octave)     bad = {bad, " note_octave"};
            if (got.velocity !== want.velocity)           bad = {bad, " velocity"};
            if (got.all_notes_off !== want.all_notes_off) bad = {bad, " all_notes_off"};
            if (got.root_note !== want.root_note)         bad = {bad, " root_note"};
            if (got.octave_shift !== want.octave_shift)   bad = {bad, " octave_shift"};
            if (got.scale_mode !== want.scale_mode)       bad = {bad, " scale_mode"};
            if (got.last !== want.last)                   bad = {bad, " last"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in%s\n  expected %s\n  actual   %s",
                             bad, describe(want), describe(got));
            end
        endfunction
    endclass

    localparam int CLOCK_HALF   = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    // frames spent with the root pinned at its top clamp before moving on
    localparam int CLAMP_FRAMES = 6;
    // octave-down pulses, enough to ride from the top clamp to the bottom one
    localparam int OCT_STEPS    = 9;
    localparam int FREE_FRAMES  = 40;
    // closing stretch of free frames run with no gaps on either side
    localparam int QUIET_FRAMES = 20;

    // Mode-button levels, packed in the same order as the request struct.
    localparam logic [6:0] BTN_PREV      = 7'b1000000;
    localparam logic [6:0] BTN_NEXT      = 7'b0100000;
    localparam logic [6:0] BTN_OCT_UP    = 7'b0010000;
    localparam logic [6:0] BTN_OCT_DOWN  = 7'b0001000;
    localparam logic [6:0] BTN_ROOT_DOWN = 7'b0000100;
    localparam logic [6:0] BTN_ROOT_UP   = 7'b0000010;
    localparam logic [6:0] BTN_PANIC     = 7'b0000001;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic push  = 1'b0;
    logic pop   = 1'b0;
    in_t  frame = '0;
    logic full;
    logic empty;
    out_t result;

    note_event_board board;
    bit              idling = 1'b1;
    int              cycles = 0;

    button_to_scale_note_mapper DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .frame  (frame),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #CLOCK_HALF clk = ~clk;

    // Guard against a hung block: end the run once the cycle budget is spent.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check every result taken at this edge against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check_event(result);
    end

    // Result side: hold pop low in random bursts while idling is on, otherwise keep popping.
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall == 0 && idling && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 11);
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    function automatic in_t frame_of(input logic [6:0] levels, input logic [3:0] press,
                                     input logic [3:0] rel);
        return {levels, press, rel};
    endfunction

    // Offer one frame request, optionally after a random gap, and hold it until taken.
    // Called at a falling edge; returns at the falling edge after the request is accepted.
    task automatic send_frame(input in_t f);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        push  <= 1'b1;
        frame <= f;
        do
            @(posedge clk);
        while (full);
        board.predict_events(f);
        @(negedge clk);
    endtask

    initial
    begin
        logic [6:0] lv;
        logic       drift;
        int         hold;
        int         k;
        board = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: empty frame, full press, full release, release of
        // empty slots, press and release together (nine results), a press that
        // replaces a held note, panic ahead of presses, a held panic level with
        // no edge, all seven buttons rising in one frame, and every scale.
        send_frame(frame_of('0, 4'h0, 4'h0));
        send_frame(frame_of('0, 4'hF, 4'h0));
        send_frame(frame_of('0, 4'h0, 4'hF));
        send_frame(frame_of('0, 4'h0, 4'hF));
        send_frame(frame_of('0, 4'hF, 4'hF));
        send_frame(frame_of('0, 4'h2, 4'h0));
        send_frame(frame_of(BTN_NEXT, 4'h2, 4'h0));
        send_frame(frame_of('0, 4'h0, 4'h2));
        send_frame(frame_of(BTN_PREV | BTN_OCT_UP | BTN_ROOT_UP, 4'h1, 4'h0));
        send_frame(frame_of('0, 4'h8, 4'h0));
        send_frame(frame_of(BTN_PANIC, 4'h4, 4'h0));
        send_frame(frame_of(BTN_PANIC, 4'h0, 4'hF));
        send_frame(frame_of('0, 4'h0, 4'h0));
        send_frame(frame_of(7'h7F, 4'hF, 4'h0));
        send_frame(frame_of('0, 4'h0, 4'hF));
        // step through every scale while the octave runs into its upper clamp
        for (k = 0; k < 5; k++)
        begin
            send_frame(frame_of(BTN_NEXT | BTN_OCT_UP, 4'hF, 4'h0));
            send_frame(frame_of('0, 4'h0, 4'hF));
        end
        // wrap the scale ring forward, mixed press and release
        send_frame(frame_of(BTN_NEXT | BTN_OCT_DOWN, 4'h5, 4'hA));

        // Random walk: toggle the root-up button every frame so each other frame
        // is an edge, climbing into the top clamp and staying there a while.
        // Drag the octave up as well so the note clamp is hit.
        drift = 1'b0;
        hold  = 0;
        while (hold < CLAMP_FRAMES)
        begin
            drift = ~drift;
            lv = '0;
            if (drift)
                lv = BTN_ROOT_UP;
            if ($urandom_range(0, 1))
                lv |= BTN_OCT_UP;
            if ($urandom_range(0, 3) == 0)
                lv |= BTN_PREV;
            if ($urandom_range(0, 3) == 0)
                lv |= BTN_NEXT;
            if ($urandom_range(0, 9) == 0)
                lv |= BTN_PANIC;
            send_frame(frame_of(lv, 4'($urandom), 4'($urandom)));
            if (board.root == int'(NOTE_MAX))
                hold++;
        end

        // Ride the octave down into its lower clamp, pressing and releasing all slots.
        for (k = 0; k < OCT_STEPS; k++)
        begin
            send_frame(frame_of(BTN_OCT_DOWN, 4'hF, 4'h0));
            send_frame(frame_of('0, 4'h0, 4'hF));
        end

        // Free frames: every bit random; drop idling for the closing stretch.
        for (k = 0; k < FREE_FRAMES; k++)
        begin
            if (k == FREE_FRAMES - QUIET_FRAMES)
                idling = 1'b0;
            send_frame(in_t'(15'($urandom)));
        end
        push <= 1'b0;

        // Drain the predictions, then give stray results a chance to show up.
        while (board.pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
